FILE: rtl/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// ssrs_pkg: shared types, codes and arithmetic for the ranging sequencer
// Request and response records, command and status codes, servo duty math.
// ----------------------------------------------------------------------------
package ssrs_pkg;

  localparam int unsigned MAIN_PERIOD_DEF = 10;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CMD_POSITION = 8'd3;
  localparam logic [7:0] CMD_AUTO     = 8'd5;
  localparam logic [7:0] CMD_SETTLE   = 8'd6;
  localparam logic [7:0] CMD_SWEEP    = 8'd7;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DUTY    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam int unsigned PWM_PERIOD   = 12500;
  localparam int unsigned WIDTH_MIN    = 720;
  localparam int unsigned DEGREE_SPAN  = 160;
  localparam int unsigned SWEEP_STEP   = 20;
  localparam int unsigned CAPTURE_WAIT = 3;
  localparam int unsigned DIST_DIV     = 477;
  localparam int unsigned DIST_MAX     = 17860;

  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] cap_a;
    logic [15:0] cap_b;
  } ssrs_req_t;

  typedef struct packed {
    logic [13:0] duty;
    logic        trig;
    logic        report;
    logic [15:0] position;
    logic [14:0] distance;
    logic [1:0]  status;
  } ssrs_rsp_t;

  // span 1960/160 = 49/4 and 12500/20000 = 5/8, each floor taken in turn, then doubled
  function automatic logic [20:0] duty_for(input logic [15:0] pos);
    logic [21:0] m;
    logic [19:0] w;
    logic [22:0] f;
    m = ({6'b0, pos} << 5) + ({6'b0, pos} << 4) + {6'b0, pos};
    w = 20'(m >> 2) + 20'(WIDTH_MIN);
    f = ({3'b0, w} << 2) + {3'b0, w};
    return {f[22:3], 1'b0};
  endfunction

endpackage

FILE: rtl/ssrs_div.sv
// ----------------------------------------------------------------------------
// ssrs_div: reciprocal divider by the distance constant
// One registered multiply by the scaled reciprocal of the divisor.
// ----------------------------------------------------------------------------
module ssrs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  output logic        busy,
  output logic        done,
  output logic [14:0] quotient
);

  // ceil(2^33 / 477); exact floor for every dividend below 2^24
  localparam int unsigned SHIFT = 33;
  localparam logic [24:0] RECIP = 25'(((64'd1 << SHIFT) + 64'(ssrs_pkg::DIST_DIV) - 64'd1)
                                      / 64'(ssrs_pkg::DIST_DIV));

  logic [47:0] prod;
  logic [14:0] q_r, q_nxt;
  logic        done_r, done_nxt;

  assign prod = 48'(dividend) * 48'(RECIP);

  always_comb begin
    q_nxt    = q_r;
    done_nxt = start;
    if (start) begin
      q_nxt = prod[SHIFT+14:SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  assign busy     = done_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/ssrs_core.sv
// ----------------------------------------------------------------------------
// ssrs_core: command decode, sweep timer and measurement sequencer state
// Applies one request per exec pulse; hands distance work to the divider.
// ----------------------------------------------------------------------------
module ssrs_core #(
  parameter int unsigned MAIN_PERIOD = ssrs_pkg::MAIN_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  ssrs_pkg::ssrs_req_t req,
  input  logic                dist_load,
  input  logic [14:0]         dist_value,
  output logic                div_start,
  output logic [23:0]         div_dividend,
  output ssrs_pkg::ssrs_rsp_t rsp
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SETTLE  = 3'd1;
  localparam logic [2:0] ST_TRIGGER = 3'd2;
  localparam logic [2:0] ST_CAPTURE = 3'd3;
  localparam logic [2:0] ST_REPORT  = 3'd4;

  localparam logic [3:0]  DIV_LAST  = 4'(MAIN_PERIOD - 1);
  localparam logic [20:0] DUTY_MAX  = 21'(ssrs_pkg::PWM_PERIOD);
  localparam logic signed [10:0] STEP  = 11'(ssrs_pkg::SWEEP_STEP);
  localparam logic signed [10:0] SPAN  = 11'(ssrs_pkg::DEGREE_SPAN);
  localparam logic [15:0] CAP_WAIT  = 16'(ssrs_pkg::CAPTURE_WAIT);

  logic [2:0]  seq_r, seq_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [3:0]  mdiv_r, mdiv_nxt;
  logic [7:0]  auto_r, auto_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic [15:0] sweep_ticks_r, sweep_ticks_nxt;
  logic [15:0] sweep_timer_r, sweep_timer_nxt;
  logic [8:0]  sweep_pos_r, sweep_pos_nxt;
  logic        rising_r, rising_nxt;
  logic [13:0] duty_val_r, duty_val_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [14:0] dist_r, dist_nxt;
  logic [13:0] duty_out_r, duty_out_nxt;
  logic        trig_r, trig_nxt;
  logic        report_r, report_nxt;
  logic [1:0]  status_r, status_nxt;

  logic [15:0] value;
  logic [15:0] duty_pos;
  logic [20:0] duty;
  logic [15:0] dif;

  assign value    = {req.hi, req.lo};
  assign duty_pos = (req.op == ssrs_pkg::OP_TICK) ? {7'b0, sweep_pos_r} : value;
  assign duty     = ssrs_pkg::duty_for(duty_pos);
  assign dif      = (req.cap_a > req.cap_b) ? (req.cap_a - req.cap_b)
                                            : (req.cap_b - req.cap_a);
  assign div_dividend = ({8'b0, dif} << 7) + ({8'b0, dif} << 1);

  always_comb begin
    logic [2:0]         seq_v;
    logic [15:0]        wait_v;
    logic [15:0]        tmr_v;
    logic signed [10:0] p;
    seq_nxt         = seq_r;
    wait_nxt        = wait_r;
    mdiv_nxt        = mdiv_r;
    auto_nxt        = auto_r;
    settle_nxt      = settle_r;
    sweep_ticks_nxt = sweep_ticks_r;
    sweep_timer_nxt = sweep_timer_r;
    sweep_pos_nxt   = sweep_pos_r;
    rising_nxt      = rising_r;
    duty_val_nxt    = duty_val_r;
    pos_nxt         = pos_r;
    dist_nxt        = dist_r;
    duty_out_nxt    = duty_out_r;
    trig_nxt        = trig_r;
    report_nxt      = report_r;
    status_nxt      = status_r;
    div_start       = 1'b0;
    seq_v           = seq_r;
    wait_v          = wait_r;
    tmr_v           = sweep_timer_r;
    p               = '0;
    if (exec) begin
      status_nxt = ssrs_pkg::STATUS_OK;
      report_nxt = 1'b0;
      if (req.op == ssrs_pkg::OP_CMD) begin
        unique case (req.code)
          ssrs_pkg::CMD_POSITION: begin
            auto_nxt = 8'd0;
            if (duty > DUTY_MAX) begin
              status_nxt = ssrs_pkg::STATUS_DUTY;
            end else begin
              pos_nxt      = value;
              duty_val_nxt = duty[13:0];
            end
            seq_nxt = ST_SETTLE;
          end
          ssrs_pkg::CMD_AUTO: begin
            seq_nxt  = ST_IDLE;
            auto_nxt = req.hi;
          end
          ssrs_pkg::CMD_SETTLE: settle_nxt = value;
          ssrs_pkg::CMD_SWEEP:  sweep_ticks_nxt = value;
          default:              status_nxt = ssrs_pkg::STATUS_UNKNOWN;
        endcase
      end else begin
        if (auto_r == 8'd0) begin
          sweep_timer_nxt = 16'd0;
        end else begin
          if (sweep_timer_r != 16'hFFFF) begin
            tmr_v = sweep_timer_r + 16'd1;
          end
          if (tmr_v < sweep_ticks_r) begin
            sweep_timer_nxt = tmr_v;
          end else begin
            sweep_timer_nxt = 16'd0;
            if (seq_v == ST_IDLE) begin
              if (duty <= DUTY_MAX) begin
                pos_nxt      = {7'b0, sweep_pos_r};
                duty_val_nxt = duty[13:0];
              end
              p = $signed({2'b0, sweep_pos_r}) + (rising_r ? STEP : -STEP);
              if (p >= SPAN) begin
                rising_nxt = 1'b0;
                p          = p - (STEP <<< 1);
              end
              if (p < 0) begin
                rising_nxt = 1'b1;
                p          = p + (STEP <<< 1);
              end
              sweep_pos_nxt = p[8:0];
              seq_v         = ST_SETTLE;
            end
          end
        end
        if (mdiv_r >= DIV_LAST) begin
          mdiv_nxt = 4'd0;
          if (seq_v != ST_IDLE) begin
            duty_out_nxt = duty_val_nxt;
          end
          unique case (seq_v)
            ST_SETTLE: begin
              if (wait_v > settle_r) begin
                wait_v   = 16'd0;
                trig_nxt = 1'b1;
                seq_v    = ST_TRIGGER;
              end
            end
            ST_TRIGGER: begin
              wait_v   = 16'd0;
              trig_nxt = 1'b0;
              seq_v    = ST_CAPTURE;
            end
            ST_CAPTURE: begin
              if (wait_v > CAP_WAIT) begin
                div_start = 1'b1;
                seq_v     = ST_REPORT;
              end
            end
            ST_REPORT: begin
              wait_v     = 16'd0;
              report_nxt = 1'b1;
              seq_v      = ST_IDLE;
            end
            default: wait_v = 16'd0;
          endcase
          if (wait_v != 16'hFFFF) begin
            wait_v = wait_v + 16'd1;
          end
          wait_nxt = wait_v;
        end else begin
          mdiv_nxt = mdiv_r + 4'd1;
        end
        seq_nxt = seq_v;
      end
    end
    if (dist_load) begin
      dist_nxt = dist_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= ST_IDLE;
      wait_r        <= 16'd0;
      mdiv_r        <= 4'd0;
      auto_r        <= 8'd0;
      settle_r      <= 16'd10;
      sweep_ticks_r <= 16'd100;
      sweep_timer_r <= 16'd0;
      sweep_pos_r   <= 9'd0;
      rising_r      <= 1'b1;
      duty_val_r    <= 14'd2124;
      pos_r         <= 16'd80;
      dist_r        <= 15'd0;
      duty_out_r    <= 14'd0;
      trig_r        <= 1'b0;
      report_r      <= 1'b0;
      status_r      <= ssrs_pkg::STATUS_OK;
    end else begin
      seq_r         <= seq_nxt;
      wait_r        <= wait_nxt;
      mdiv_r        <= mdiv_nxt;
      auto_r        <= auto_nxt;
      settle_r      <= settle_nxt;
      sweep_ticks_r <= sweep_ticks_nxt;
      sweep_timer_r <= sweep_timer_nxt;
      sweep_pos_r   <= sweep_pos_nxt;
      rising_r      <= rising_nxt;
      duty_val_r    <= duty_val_nxt;
      pos_r         <= pos_nxt;
      dist_r        <= dist_nxt;
      duty_out_r    <= duty_out_nxt;
      trig_r        <= trig_nxt;
      report_r      <= report_nxt;
      status_r      <= status_nxt;
    end
  end

  assign rsp.duty     = duty_out_r;
  assign rsp.trig     = trig_r;
  assign rsp.report   = report_r;
  assign rsp.position = pos_r;
  assign rsp.distance = dist_r;
  assign rsp.status   = status_r;

endmodule

FILE: rtl/servo_sweep_ranging_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_sweep_ranging_sequencer_unit: servo aiming and range measurement
// Takes command and tick requests, returns one response per request.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   in      | request   | in_valid, in_ready, in_operation .. capture_second
//   out     | response  | out_valid, out_ready, out_pwm_duty .. out_status
//
// A request passes through accept, update and response load; a tick that
// completes a capture also waits in the reciprocal multiplier before the load.
// Reset: rst_n, synchronous, restores all sequencer and sweep state.
// in_ready is low while a request is in work; a stalled response holds the
// block until out_ready takes it.
// ----------------------------------------------------------------------------
module servo_sweep_ranging_sequencer_unit #(
  parameter int unsigned MAIN_PERIOD = ssrs_pkg::MAIN_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_cmd_code,
  input  logic [7:0]  in_cmd_hi,
  input  logic [7:0]  in_cmd_lo,
  input  logic [15:0] in_capture_first,
  input  logic [15:0] in_capture_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_pwm_duty,
  output logic        out_trigger,
  output logic        out_report_valid,
  output logic [15:0] out_report_position,
  output logic [14:0] out_report_distance,
  output logic [1:0]  out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  ssrs_pkg::ssrs_req_t req_r;
  ssrs_pkg::ssrs_rsp_t rsp;
  ssrs_pkg::ssrs_rsp_t out_r;
  logic                out_valid_r, out_valid_nxt;
  logic                load_out;
  logic                div_start;
  logic [23:0]         div_dividend;
  logic                div_busy;
  logic                div_done;
  logic [14:0]         div_q;

  ssrs_core #(
    .MAIN_PERIOD(MAIN_PERIOD)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .exec        (state_r == S_EXEC),
    .req         (req_r),
    .dist_load   (div_done),
    .dist_value  (div_q),
    .div_start   (div_start),
    .div_dividend(div_dividend),
    .rsp         (rsp)
  );

  ssrs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = div_start ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.op    <= in_operation;
      req_r.code  <= in_cmd_code;
      req_r.hi    <= in_cmd_hi;
      req_r.lo    <= in_cmd_lo;
      req_r.cap_a <= in_capture_first;
      req_r.cap_b <= in_capture_second;
    end
    if (load_out) begin
      out_r <= rsp;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pwm_duty        = out_r.duty;
  assign out_trigger         = out_r.trig;
  assign out_report_valid    = out_r.report;
  assign out_report_position = out_r.position;
  assign out_report_distance = out_r.distance;
  assign out_status          = out_r.status;

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execution");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside division state");

  a_resp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("response raised outside output state");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.distance <= 15'(ssrs_pkg::DIST_MAX)))
    else $error("distance out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status != 2'd3))
    else $error("invalid status code");
`endif

endmodule
